/* rtl/igov_pkg.sv */
// ----------------------------------------------------------------------------
// igov_pkg
// Shared types, codes and lookup functions of the idle timeout power governor.
// ----------------------------------------------------------------------------
package igov_pkg;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;
   localparam int ReqDataWidth = 56;
   localparam int RspDataWidth = 144;

   localparam logic [15:0] FAST_SCAN_MS   = 16'd1;
   localparam logic [13:0] HB_SHORT_MS    = 14'd5000;
   localparam logic [13:0] HB_MEDIUM_MS   = 14'd10000;
   localparam logic [13:0] HB_LONG_MS     = 14'd15000;

   localparam logic [CsrAddrWidth-1:0] CSR_NORMAL_SCAN    = 4'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_EFFICIENT_SCAN = 4'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_DEEP_SCAN      = 4'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_ACTIVE_IDLE    = 4'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_NORMAL_IDLE    = 4'd4;
   localparam logic [CsrAddrWidth-1:0] CSR_EFFICIENT_IDLE = 4'd5;
   localparam logic [CsrAddrWidth-1:0] CSR_LOW_BATT       = 4'd6;
   localparam logic [CsrAddrWidth-1:0] CSR_CRIT_BATT      = 4'd7;

   typedef enum logic [2:0] {
      CMD_TICK         = 3'd0,
      CMD_ACTIVITY     = 3'd1,
      CMD_FORCE_ACTIVE = 3'd2,
      CMD_BATTERY      = 3'd3,
      CMD_SET_MODE     = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_WAKE,
      OP_BATTERY,
      OP_SET_MODE
   } op_type;

   typedef enum logic [1:0] {
      MODE_ACTIVE    = 2'd0,
      MODE_NORMAL    = 2'd1,
      MODE_EFFICIENT = 2'd2,
      MODE_DEEP      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      LEVEL_ACTIVE  = 2'd0,
      LEVEL_REDUCED = 2'd1,
      LEVEL_MINIMAL = 2'd2
   } level_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] time_ms;
      logic [15:0] supply_mv;
      logic        usb_on;
      mode_type    mode_request;
   } item_type;

   typedef struct packed {
      mode_type    power_mode;
      logic [15:0] matrix_interval_ms;
      logic [13:0] heartbeat_interval_ms;
      level_type   matrix_level;
      level_type   heartbeat_level;
      level_type   battery_level;
      logic        batt_low;
      logic        batt_crit;
      logic        usb_present;
      logic [31:0] transition_count;
      logic [31:0] scan_count;
      logic [31:0] batt_reads;
   } result_type;

   function automatic logic [13:0] heartbeat_of(mode_type m);
      logic [13:0] hb;
      unique case (m)
         MODE_EFFICIENT: hb = HB_MEDIUM_MS;
         MODE_DEEP:      hb = HB_LONG_MS;
         default:        hb = HB_SHORT_MS;
      endcase
      return hb;
   endfunction

   function automatic level_type matrix_level_of(mode_type m);
      level_type lv;
      unique case (m)
         MODE_ACTIVE: lv = LEVEL_ACTIVE;
         MODE_NORMAL: lv = LEVEL_REDUCED;
         default:     lv = LEVEL_MINIMAL;
      endcase
      return lv;
   endfunction

   function automatic level_type other_level_of(mode_type m);
      level_type lv;
      unique case (m)
         MODE_EFFICIENT: lv = LEVEL_REDUCED;
         MODE_DEEP:      lv = LEVEL_MINIMAL;
         default:        lv = LEVEL_ACTIVE;
      endcase
      return lv;
   endfunction

endpackage

/* rtl/igov_front.sv */
// ----------------------------------------------------------------------------
// igov_front
// Request intake: registers each request and decodes its command.
// ----------------------------------------------------------------------------
module igov_front import igov_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2:0]              req_tuser,  // cmd
   input  logic [ReqDataWidth-1:0] req_tdata,  // time_ms, supply_mv, usb_on, mode_request
   output logic                    item_valid,
   input  logic                    item_ready,
   output item_type                item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_tready = !valid_ff || item_ready;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      item_in              = item_ff;
      item_in.time_ms      = req_tdata[31:0];
      item_in.supply_mv    = req_tdata[47:32];
      item_in.usb_on       = req_tdata[48];
      item_in.mode_request = mode_type'(req_tdata[50:49]);
      unique case (cmd_type'(req_tuser))
         CMD_TICK:         item_in.op = OP_TICK;
         CMD_ACTIVITY:     item_in.op = OP_WAKE;
         CMD_FORCE_ACTIVE: item_in.op = OP_WAKE;
         CMD_BATTERY:      item_in.op = OP_BATTERY;
         CMD_SET_MODE:     item_in.op = OP_SET_MODE;
         default:          item_in.op = OP_NOP;
      endcase
      valid_in = load || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/igov_queue.sv */
// ----------------------------------------------------------------------------
// igov_queue
// Two-entry queue between the decode front and the execute back end.
// ----------------------------------------------------------------------------
module igov_queue import igov_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (count_ff != 2'd3)
            else $error("queue count out of range");
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue overfilled");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count missed a push");
   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");

endmodule

/* rtl/igov_back.sv */
// ----------------------------------------------------------------------------
// igov_back
// Execute stage: configuration registers, governor state and result register.
// ----------------------------------------------------------------------------
module igov_back import igov_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  item_type                item,
   output logic                    result_valid,
   input  logic                    result_ready,
   output result_type              result
);

   logic [15:0] normal_scan_ff, efficient_scan_ff, deep_scan_ff;
   logic [31:0] active_idle_ff, normal_idle_ff, efficient_idle_ff;
   logic [15:0] low_batt_ff, crit_batt_ff;

   mode_type    mode_ff, mode_in;
   logic [31:0] last_act_ff, last_act_in;
   logic        low_ff, low_in, crit_ff, crit_in, usb_ff, usb_in;
   logic [31:0] trans_ff, trans_in, scans_ff, scans_in, reads_ff, reads_in;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        pop;
   logic [31:0] idle;
   mode_type    tick_mode;

   assign item_ready = !rsp_valid_ff || result_ready;
   assign pop        = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_scan_ff    <= 16'd5;
         efficient_scan_ff <= 16'd25;
         deep_scan_ff      <= 16'd100;
         active_idle_ff    <= 32'd5000;
         normal_idle_ff    <= 32'd20000;
         efficient_idle_ff <= 32'd90000;
         low_batt_ff       <= 16'd3200;
         crit_batt_ff      <= 16'd3000;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_NORMAL_SCAN:    normal_scan_ff    <= csr_wdata[15:0];
            CSR_EFFICIENT_SCAN: efficient_scan_ff <= csr_wdata[15:0];
            CSR_DEEP_SCAN:      deep_scan_ff      <= csr_wdata[15:0];
            CSR_ACTIVE_IDLE:    active_idle_ff    <= csr_wdata;
            CSR_NORMAL_IDLE:    normal_idle_ff    <= csr_wdata;
            CSR_EFFICIENT_IDLE: efficient_idle_ff <= csr_wdata;
            CSR_LOW_BATT:       low_batt_ff       <= csr_wdata[15:0];
            CSR_CRIT_BATT:      crit_batt_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // idle time wraps modulo 2^32
   assign idle = item.time_ms - last_act_ff;

   always_comb begin
      priority if (idle < active_idle_ff) begin
         tick_mode = MODE_ACTIVE;
      end else if (idle < normal_idle_ff) begin
         tick_mode = MODE_NORMAL;
      end else if (idle < efficient_idle_ff) begin
         tick_mode = MODE_EFFICIENT;
      end else begin
         tick_mode = MODE_DEEP;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      last_act_in = last_act_ff;
      low_in      = low_ff;
      crit_in     = crit_ff;
      usb_in      = usb_ff;
      trans_in    = trans_ff;
      scans_in    = scans_ff;
      reads_in    = reads_ff;
      if (pop) begin
         unique case (item.op)
            OP_TICK: begin
               mode_in = tick_mode;
               if (tick_mode != mode_ff) begin
                  trans_in = trans_ff + 32'd1;
               end
            end
            OP_WAKE: begin
               mode_in     = MODE_ACTIVE;
               last_act_in = item.time_ms;
               scans_in    = scans_ff + 32'd1;
               if (mode_ff != MODE_ACTIVE) begin
                  trans_in = trans_ff + 32'd1;
               end
            end
            OP_BATTERY: begin
               usb_in   = item.usb_on;
               low_in   = item.supply_mv < low_batt_ff;
               crit_in  = item.supply_mv < crit_batt_ff;
               reads_in = reads_ff + 32'd1;
            end
            OP_SET_MODE: begin
               mode_in = item.mode_request;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_in.power_mode = mode_in;
      unique case (mode_in)
         MODE_ACTIVE:    rsp_in.matrix_interval_ms = FAST_SCAN_MS;
         MODE_NORMAL:    rsp_in.matrix_interval_ms = normal_scan_ff;
         MODE_EFFICIENT: rsp_in.matrix_interval_ms = efficient_scan_ff;
         default:        rsp_in.matrix_interval_ms = deep_scan_ff;
      endcase
      rsp_in.heartbeat_interval_ms = heartbeat_of(mode_in);
      rsp_in.matrix_level          = matrix_level_of(mode_in);
      rsp_in.heartbeat_level       = other_level_of(mode_in);
      rsp_in.battery_level         = other_level_of(mode_in);
      rsp_in.batt_low              = low_in;
      rsp_in.batt_crit             = crit_in;
      rsp_in.usb_present           = usb_in;
      rsp_in.transition_count      = trans_in;
      rsp_in.scan_count            = scans_in;
      rsp_in.batt_reads            = reads_in;
      rsp_valid_in = pop || (rsp_valid_ff && !result_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ACTIVE;
         last_act_ff  <= 32'd0;
         low_ff       <= 1'b0;
         crit_ff      <= 1'b0;
         usb_ff       <= 1'b0;
         trans_ff     <= 32'd0;
         scans_ff     <= 32'd0;
         reads_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         last_act_ff  <= last_act_in;
         low_ff       <= low_in;
         crit_ff      <= crit_in;
         usb_ff       <= usb_in;
         trans_ff     <= trans_in;
         scans_ff     <= scans_in;
         reads_ff     <= reads_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign result_valid = rsp_valid_ff;
   assign result       = rsp_ff;

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(trans_ff) && $stable(mode_ff))
      else $error("state changed without a request");
   a_set_no_count: assert property (@(posedge clock) disable iff (reset)
      pop && item.op == OP_SET_MODE |=> $stable(trans_ff))
      else $error("set-mode counted a transition");
   a_wake_active: assert property (@(posedge clock) disable iff (reset)
      pop && item.op == OP_WAKE |=>
         mode_ff == MODE_ACTIVE && scans_ff == $past(scans_ff) + 32'd1)
      else $error("wake request did not return to active");
   a_result_mode: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_ff.power_mode == mode_ff)
      else $error("result mode differs from state");

endmodule

/* rtl/idle_timeout_power_mode_governor_unit.sv */
// ----------------------------------------------------------------------------
// idle_timeout_power_mode_governor_unit
// Four-level idle timeout power mode governor with a streaming request port.
// ----------------------------------------------------------------------------
// Accepts one request per clock while the result port does not stall, and
// returns one result per request, in order. Each request passes through the
// decode register, the queue and the result register; the sustained rate of
// one request per cycle is set by the state update in the execute stage,
// which does the idle subtraction, three limit compares and counter increments.
// Configuration writes through the csr_ port take effect on the next cycle.
module idle_timeout_power_mode_governor_unit import igov_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2:0]              req_tuser,  // cmd
   input  logic [ReqDataWidth-1:0] req_tdata,  // time_ms, supply_mv, usb_on, mode_request
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // power_mode, matrix_interval_ms, heartbeat_interval_ms, matrix_level,
   // heartbeat_level, battery_level, batt_low, batt_crit,
   // usb_present, transition_count, scan_count, batt_reads
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_wen,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   item_type   fq_item, qb_item;
   result_type result;

   igov_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (fq_valid),
      .item_ready (fq_ready),
      .item       (fq_item)
   );

   igov_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   igov_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .item_valid   (qb_valid),
      .item_ready   (qb_ready),
      .item         (qb_item),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {7'd0,
                       result.batt_reads,
                       result.scan_count,
                       result.transition_count,
                       result.usb_present,
                       result.batt_crit,
                       result.batt_low,
                       result.battery_level,
                       result.heartbeat_level,
                       result.matrix_level,
                       result.heartbeat_interval_ms,
                       result.matrix_interval_ms,
                       result.power_mode};

endmodule
